// File: hdl/cba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

  localparam int WORD_W  = 16;
  localparam int WORD_LW = 4;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ST_W    = 2;
  localparam int PW      = CNT_W - WORD_LW;
  localparam int IN_TW   = 24;
  localparam int OUT_TW  = 16;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int SIZE_RST       = 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic rmw;
    logic clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic need_rmw;
    logic found;
    logic scan_end;
    logic rmw_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/cba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cba_pkg::sts_t sts,
  output cba_pkg::cmd_t cmd
);
  import cba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (sts.need_scan) state_nxt = S_SCAN;
          else if (sts.need_rmw) state_nxt = S_RMW;
          else state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.found) state_nxt = S_RMW;
        else if (sts.scan_end) state_nxt = S_RESP;
      end
      S_RMW: begin
        if (sts.rmw_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_RMW:  cmd.rmw  = 1'b1;
      S_RESP: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/cba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_dp #(
  parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cba_pkg::cmd_t             cmd,
  output cba_pkg::sts_t             sts,
  input  logic                      req_op,
  input  logic [cba_pkg::IDX_W-1:0] req_start,
  input  logic [cba_pkg::CNT_W-1:0] req_count,
  input  logic                      cfg_we,
  input  logic [cba_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [cba_pkg::ST_W-1:0]  out_status,
  output logic [cba_pkg::IDX_W-1:0] out_run_start
);
  import cba_pkg::*;

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int DEPTH     = 1 << AW;
  localparam int SIZE_CAP  = (NUM_BLOCKS < 2047) ? NUM_BLOCKS : 2047;
  localparam logic [CNT_W-1:0] SIZE_MAX  = CNT_W'(SIZE_CAP);
  localparam logic [CNT_W-1:0] SIZE_INIT =
    CNT_W'((SIZE_RST < NUM_BLOCKS) ? SIZE_RST : NUM_BLOCKS);

  // map storage, one word of block bits per entry, 1 = used
  logic [WORD_W-1:0] map_mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra;
  logic [WORD_W-1:0] wd;

  logic [CNT_W-1:0]  size_r;
  logic [AW-1:0]     clr_ptr_r;
  logic [PW:0]       ptr_r;
  logic [PW:0]       ptr_nxt;
  logic              dv_r;
  logic              dv_nxt;
  logic [PW-1:0]     dw_r;
  logic [PW-1:0]     dw_nxt;
  logic              set_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  lo_r;
  logic [CNT_W-1:0]  lo_nxt;
  logic [CNT_W-1:0]  hi_r;
  logic [CNT_W-1:0]  hi_nxt;
  logic [CNT_W-1:0]  run_r;
  logic [CNT_W-1:0]  run_nxt;
  status_t           res_st_r;
  status_t           res_st_nxt;
  logic [IDX_W-1:0]  res_rs_r;
  logic [IDX_W-1:0]  res_rs_nxt;
  logic              out_valid_r;
  status_t           out_st_r;
  logic [IDX_W-1:0]  out_rs_r;

  logic [CNT_W:0]    req_sum;
  logic              req_err;
  logic              req_zero;
  logic [CNT_W:0]    size_round;
  logic [PW:0]       nw;
  logic [PW:0]       hiw;
  logic              issue;

  logic [CNT_W-1:0]  base;
  logic [WORD_W-1:0] free_b;
  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] mask;
  logic [WORD_LW:0]  lu [WORD_W];
  logic [CNT_W:0]    tot;
  logic [CNT_W:0]    pos;
  logic [WORD_LW-1:0] hj;
  logic              any_hit;
  logic              found;
  logic [CNT_W-1:0]  epos;
  logic [CNT_W-1:0]  fstart;

  always_ff @(posedge clk) begin
    if (we) map_mem_r[wa] <= wd;
    rdata_r <= map_mem_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_INIT;
    end else if (cfg_we) begin
      if (int'(cfg_wdata) > NUM_BLOCKS) size_r <= SIZE_MAX;
      else size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clear) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
    end
  end

  // request decode
  always_comb begin
    req_sum  = {1'b0, CNT_W'(req_start)} + {1'b0, req_count};
    req_err  = req_sum > {1'b0, size_r};
    req_zero = (req_count == '0);
  end

  always_comb begin
    size_round = {1'b0, size_r} + (CNT_W+1)'(WORD_W - 1);
    nw         = size_round[CNT_W:WORD_LW];
    hiw        = {1'b0, hi_r[CNT_W-1:WORD_LW]};
    issue      = cmd.scan ? (ptr_r < nw) : (ptr_r <= hiw);
    base       = {dw_r, {WORD_LW{1'b0}}};
  end

  // per-word run search
  always_comb begin
    hit    = '0;
    free_b = '0;
    mask   = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos       = {1'b0, base} + (CNT_W+1)'(j);
      free_b[j] = (pos < {1'b0, size_r}) && !rdata_r[j];
      mask[j]   = (pos >= {1'b0, lo_r}) && (pos <= {1'b0, hi_r});
    end
    for (int j = 0; j < WORD_W; j++) begin
      lu[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (!free_b[k]) lu[j] = (WORD_LW+1)'(k + 1);
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (lu[j] == '0) tot = {1'b0, run_r} + (CNT_W+1)'(j + 1);
      else tot = (CNT_W+1)'((WORD_LW+1)'(j + 1) - lu[j]);
      hit[j] = tot >= {1'b0, cnt_r};
    end
    hj      = '0;
    any_hit = 1'b0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hj      = WORD_LW'(j);
        any_hit = 1'b1;
      end
    end
    found  = cmd.scan && dv_r && any_hit;
    epos   = base + CNT_W'(hj);
    fstart = epos + 1'b1 - cnt_r;
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    dv_nxt     = dv_r;
    dw_nxt     = dw_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    run_nxt    = run_r;
    res_st_nxt = res_st_r;
    res_rs_nxt = res_rs_r;
    if (cmd.accept) begin
      ptr_nxt = (req_op == OP_ALLOC) ? '0 : (PW+1)'(req_start[IDX_W-1:WORD_LW]);
      dv_nxt  = 1'b0;
      run_nxt = '0;
      lo_nxt  = CNT_W'(req_start);
      hi_nxt  = CNT_W'(req_sum - 1'b1);
      if (req_op == OP_FREE) res_st_nxt = req_err ? ST_RANGE : ST_OK;
      else res_st_nxt = ST_NOSPACE;
      res_rs_nxt = '0;
    end else if (found) begin
      ptr_nxt    = {1'b0, fstart[CNT_W-1:WORD_LW]};
      dv_nxt     = 1'b0;
      lo_nxt     = fstart;
      hi_nxt     = epos;
      res_st_nxt = ST_OK;
      res_rs_nxt = fstart[IDX_W-1:0];
    end else if (cmd.scan || cmd.rmw) begin
      if (issue) begin
        ptr_nxt = ptr_r + 1'b1;
        dv_nxt  = 1'b1;
        dw_nxt  = ptr_r[PW-1:0];
      end else begin
        dv_nxt = 1'b0;
      end
      if (cmd.scan && dv_r) begin
        if (lu[WORD_W-1] == '0) run_nxt = run_r + CNT_W'(WORD_W);
        else run_nxt = CNT_W'((WORD_LW+1)'(WORD_W) - lu[WORD_W-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      dv_r  <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      dv_r  <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dw_r     <= dw_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    run_r    <= run_nxt;
    res_st_r <= res_st_nxt;
    res_rs_r <= res_rs_nxt;
    if (cmd.accept) begin
      cnt_r <= req_count;
      set_r <= (req_op == OP_ALLOC);
    end
  end

  always_comb begin
    ra = AW'(ptr_r[PW-1:0]);
    we = cmd.clear || (cmd.rmw && dv_r);
    wa = cmd.clear ? clr_ptr_r : AW'(dw_r);
    if (cmd.clear) wd = '0;
    else if (set_r) wd = rdata_r | mask;
    else wd = rdata_r & ~mask;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_st_r <= res_st_r;
      out_rs_r <= res_rs_r;
    end
  end

  always_comb begin
    sts.clr_done  = cmd.clear && (&clr_ptr_r);
    sts.need_scan = (req_op == OP_ALLOC) && !req_zero;
    sts.need_rmw  = (req_op == OP_FREE) && !req_zero && !req_err;
    sts.found     = found;
    sts.scan_end  = cmd.scan && !dv_r && !issue;
    sts.rmw_done  = cmd.rmw && !dv_r && !issue;
    sts.out_busy  = out_valid_r && !out_tready;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_run_start = out_rs_r;

endmodule
`default_nettype wire

// File: hdl/contiguous_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator over a used/free bitmap of NUM_BLOCKS storage blocks.
// in_*  : one request per item. in_tuser = op (0 allocate, 1 free),
//         in_tdata = start_index, count.
// out_* : one result per request: status, run_start.
// cfg_* : cfg_we writes active_blocks (size of the scanned map).
// The map lives in a 16-bit-word memory with registered reads; one word is
// read, and for updates written back, each cycle.
// Allocate: scan of ceil(size/16) words, one per cycle, stops at the first
// word that completes a run; then marking of the run's words, one per cycle.
// Free: clearing of the run's bits in each word it touches; a refused or
// empty request skips the map and goes straight to its result.
// One request is in work at a time; in_tready is high when the block is idle,
// so a new request is taken only after the last one's result is loaded.
// After reset the map is cleared in a pass of one word a cycle over all
// 2**ceil(log2(ceil(NUM_BLOCKS/16))) words (64 at 1024 blocks) with in_tready
// low; active_blocks returns to min(1024, NUM_BLOCKS). A result waits in an
// output register while out_tready is low; the next request is accepted
// meanwhile and its result waits until the register is free.
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cba_pkg::IN_TW-1:0]  in_tdata,   // start_index, count
  input  logic                       in_tuser,   // op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cba_pkg::OUT_TW-1:0] out_tdata,  // status, run_start
  input  logic                       cfg_we,
  input  logic [cba_pkg::CNT_W-1:0]  cfg_wdata
);
  import cba_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [ST_W-1:0]  out_status;
  logic [IDX_W-1:0] out_run_start;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_op        (in_tuser),
    .req_start     (in_tdata[IDX_W-1:0]),
    .req_count     (in_tdata[IDX_W+CNT_W-1:IDX_W]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_status    (out_status),
    .out_run_start (out_run_start)
  );

  assign out_tdata = {{(OUT_TW-ST_W-IDX_W){1'b0}}, out_run_start, out_status};

endmodule
`default_nettype wire

// File: hdl/cba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cba_pkg::OUT_TW-1:0] out_tdata
);
  import cba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channels active right after reset");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ST_W-1:0] <= ST_RANGE)
    else $error("undefined status code");

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[ST_W-1:0] != ST_OK) |-> out_tdata[ST_W+IDX_W-1:ST_W] == '0)
    else $error("run_start nonzero on failed request");

endmodule

bind contiguous_block_allocator cba_port_checker u_cba_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
